### hdl/irb_pkg.sv
package irb_pkg;

    localparam int IMG_SIZE  = 256;
    localparam int FRAC_BITS = 8;
    localparam int Q_BITS    = 14;

    localparam int FIELD_W   = 8;
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int COORD_W    = $clog2(IMG_SIZE);
    localparam int BANK_AW    = 2 * (COORD_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;

    localparam int DIFF_W = FIELD_W + 1;
    localparam int PROD_W = CFG_W + DIFF_W;
    localparam int SRC_W  = PROD_W + 2;

    localparam logic signed [SRC_W-1:0] SRC_LIM = SRC_W'(longint'(IMG_SIZE) << Q_BITS);

    localparam int WGT_W = FRAC_BITS + 1;
    localparam int TOP_W = FRAC_BITS + PIX_W;
    localparam int ACC_W = 2 * FRAC_BITS + PIX_W + 1;
    localparam int ONE   = 1 << FRAC_BITS;
    localparam int RND   = 1 << (2 * FRAC_BITS - 1);

    localparam logic signed [CFG_W-1:0] COS_RESET    = 16'sd16384;
    localparam logic signed [CFG_W-1:0] SIN_RESET    = 16'sd0;
    localparam logic [PIX_W-1:0]        CENTER_RESET = 8'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS    = 2'd0,
        CFG_SIN    = 2'd1,
        CFG_CENTER = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    typedef struct packed {
        logic               query;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic [FIELD_W-1:0] pix;
    } t_item;

    typedef struct packed {
        t_item                item;
        logic                 hit;
        logic [COORD_W-1:0]   r0;
        logic [COORD_W-1:0]   c0;
        logic [FRAC_BITS-1:0] fr;
        logic [FRAC_BITS-1:0] fc;
    } t_src;

    typedef struct packed {
        logic                 hit;
        logic [FRAC_BITS-1:0] fr;
        logic [FRAC_BITS-1:0] fc;
        logic [PIX_W-1:0]     a;
        logic [PIX_W-1:0]     b;
        logic [PIX_W-1:0]     c;
        logic [PIX_W-1:0]     d;
    } t_quad;

endpackage

### hdl/irb_req_if.sv
interface irb_req_if import irb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    logic [FIELD_W-1:0] pixel_in;

    modport source (output valid, output req_type, output row, output col, output pixel_in,
                    input ready);
    modport sink (input valid, input req_type, input row, input col, input pixel_in,
                  output ready);
endinterface

### hdl/irb_res_if.sv
interface irb_res_if import irb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             inside_res;

    modport source (output valid, output pixel_out, output inside_res, input ready);
    modport sink (input valid, input pixel_out, input inside_res, output ready);
endinterface

### hdl/image_rotate_bilinear.sv
// channel  | dir | handshake       | word
// ---------+-----+-----------------+-----------------------------------
// i_req    | in  | valid / ready   | req_type, row, col, pixel_in
// o_res    | out | valid / ready   | pixel_out, inside_res
// i_cfg    | in  | i_cfg_we only   | i_cfg_idx, i_cfg_data
//
// one word per clock while o_res is not stalled; a query's result leaves from the rounding stage
// seven register stages: offsets, products, source point, bank read, row blend,
// column weights, rounding; four parity banks give all neighbours in one read
// synchronous active-low reset clears valid bits and config; frame store is not cleared
// each stage holds when the next is full and stalled; bubbles are squeezed out
module image_rotate_bilinear import irb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    irb_req_if.sink              i_req,
    irb_res_if.source            o_res
);

    logic signed [CFG_W-1:0] r_cos, r_sin;
    logic [PIX_W-1:0]        r_center;

    logic  map_v, map_rdy, fet_v, fet_rdy;
    t_src  map_src;
    t_quad fet_quad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos    <= COS_RESET;
            r_sin    <= SIN_RESET;
            r_center <= CENTER_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COS: begin
                    r_cos <= $signed(i_cfg_data);
                end
                CFG_SIN: begin
                    r_sin <= $signed(i_cfg_data);
                end
                CFG_CENTER: begin
                    r_center <= i_cfg_data[PIX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    irb_map u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cos    (r_cos),
        .i_sin    (r_sin),
        .i_center (r_center),
        .i_req    (i_req),
        .o_valid  (map_v),
        .o_src    (map_src),
        .i_ready  (map_rdy)
    );

    irb_fetch u_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (map_v),
        .i_src   (map_src),
        .o_ready (map_rdy),
        .o_valid (fet_v),
        .o_quad  (fet_quad),
        .i_ready (fet_rdy)
    );

    irb_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fet_v),
        .i_quad  (fet_quad),
        .o_ready (fet_rdy),
        .o_res   (o_res)
    );

    a_outside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.inside_res |-> o_res.pixel_out == '0)
        else $error("outside point gave a nonzero pixel");

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_req.ready)
        else $error("input stalled while output register empty");

    a_load_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_v && map_rdy && (map_src.item.query == REQ_LOAD) |=> !fet_v)
        else $error("load word reached the blend stages");

endmodule

### hdl/irb_ram.sv
module irb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/irb_map.sv
module irb_map import irb_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic signed [CFG_W-1:0] i_cos,
    input  logic signed [CFG_W-1:0] i_sin,
    input  logic [PIX_W-1:0]        i_center,
    irb_req_if.sink                 i_req,
    output logic                    o_valid,
    output t_src                    o_src,
    input  logic                    i_ready
);

    logic rdy1, rdy2, rdy3;

    logic                     r_v1, r_v2, r_v3;
    t_item                    r_it1, r_it2;
    logic signed [DIFF_W-1:0] r_dr1, r_dc1;
    logic signed [PROD_W-1:0] r_pcr, r_psc, r_psr, r_pcc;
    t_src                     r_src3;

    t_item                    n_it1;
    logic signed [DIFF_W-1:0] n_dr1, n_dc1;
    logic signed [PROD_W-1:0] n_pcr, n_psc, n_psr, n_pcc;
    logic signed [SRC_W-1:0]  n_cq, n_sr, n_sc;
    t_src                     n_src3;

    assign rdy3        = !r_v3 || i_ready;
    assign rdy2        = !r_v2 || rdy3;
    assign rdy1        = !r_v1 || rdy2;
    assign i_req.ready = rdy1;

    // stage 1: offsets from the centre
    always_comb begin
        n_it1.query = i_req.req_type;
        n_it1.row   = i_req.row;
        n_it1.col   = i_req.col;
        n_it1.pix   = i_req.pixel_in;
        n_dr1       = $signed({1'b0, i_req.row}) - $signed({1'b0, i_center});
        n_dc1       = $signed({1'b0, i_req.col}) - $signed({1'b0, i_center});
    end

    // stage 2: rotation products
    always_comb begin
        n_pcr = PROD_W'(i_cos) * PROD_W'(r_dr1);
        n_psc = PROD_W'(i_sin) * PROD_W'(r_dc1);
        n_psr = PROD_W'(i_sin) * PROD_W'(r_dr1);
        n_pcc = PROD_W'(i_cos) * PROD_W'(r_dc1);
    end

    // stage 3: source point, range test and split into integer and fraction
    always_comb begin
        n_cq          = $signed(SRC_W'({i_center, {Q_BITS{1'b0}}}));
        n_sr          = SRC_W'(r_pcr) - SRC_W'(r_psc) + n_cq;
        n_sc          = SRC_W'(r_psr) + SRC_W'(r_pcc) + n_cq;
        n_src3.item   = r_it2;
        n_src3.hit    = !n_sr[SRC_W-1] && !n_sc[SRC_W-1] && (n_sr < SRC_LIM)
                        && (n_sc < SRC_LIM);
        n_src3.r0     = n_sr[Q_BITS +: COORD_W];
        n_src3.c0     = n_sc[Q_BITS +: COORD_W];
        n_src3.fr     = n_sr[Q_BITS-FRAC_BITS +: FRAC_BITS];
        n_src3.fc     = n_sc[Q_BITS-FRAC_BITS +: FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_req.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_req.valid) begin
            r_it1 <= n_it1;
            r_dr1 <= n_dr1;
            r_dc1 <= n_dc1;
        end
        if (rdy2 && r_v1) begin
            r_it2 <= r_it1;
            r_pcr <= n_pcr;
            r_psc <= n_psc;
            r_psr <= n_psr;
            r_pcc <= n_pcc;
        end
        if (rdy3 && r_v2) begin
            r_src3 <= n_src3;
        end
    end

    assign o_valid = r_v3;
    assign o_src   = r_src3;

endmodule

### hdl/irb_fetch.sv
module irb_fetch import irb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_src  i_src,
    output logic  o_ready,
    output logic  o_valid,
    output t_quad o_quad,
    input  logic  i_ready
);

    logic               adv, rd_en, wr_en, in_frame, rcl, ccl;
    logic [COORD_W-1:0] r1, c1, lrow, lcol;
    logic [COORD_W-1:0] rsel [2];
    logic [COORD_W-1:0] csel [2];
    logic [PIX_W-1:0]   rd [4];
    logic               r1p, c1p;

    logic                 r_v4, r_inside, r_r0p, r_c0p, r_rcl, r_ccl;
    logic [FRAC_BITS-1:0] r_fr, r_fc;

    assign o_ready = !r_v4 || i_ready;
    assign adv     = i_valid && o_ready;

    assign lrow     = COORD_W'(i_src.item.row);
    assign lcol     = COORD_W'(i_src.item.col);
    assign in_frame = (32'(i_src.item.row) < IMG_SIZE) && (32'(i_src.item.col) < IMG_SIZE);
    assign rd_en    = adv && (i_src.item.query == REQ_QUERY);
    assign wr_en    = adv && (i_src.item.query == REQ_LOAD) && in_frame;

    // right and bottom neighbours clamp to the last row and column
    assign rcl = (i_src.r0 == COORD_W'(IMG_SIZE - 1));
    assign ccl = (i_src.c0 == COORD_W'(IMG_SIZE - 1));
    assign r1  = rcl ? i_src.r0 : i_src.r0 + 1'b1;
    assign c1  = ccl ? i_src.c0 : i_src.c0 + 1'b1;

    // banked by row and column parity so all four neighbours read at once
    for (genvar p = 0; p < 2; p++) begin : g_sel
        assign rsel[p] = (i_src.r0[0] == 1'(p)) ? i_src.r0 : r1;
        assign csel[p] = (i_src.c0[0] == 1'(p)) ? i_src.c0 : c1;
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam int P = b / 2;
        localparam int Q = b % 2;
        irb_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (wr_en && (lrow[0] == 1'(P)) && (lcol[0] == 1'(Q))),
            .i_waddr ({lrow[COORD_W-1:1], lcol[COORD_W-1:1]}),
            .i_wdata (i_src.item.pix),
            .i_re    (rd_en),
            .i_raddr ({rsel[P][COORD_W-1:1], csel[Q][COORD_W-1:1]}),
            .o_rdata (rd[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (o_ready) begin
            r_v4 <= i_valid && (i_src.item.query == REQ_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_inside <= i_src.hit;
            r_fr     <= i_src.fr;
            r_fc     <= i_src.fc;
            r_r0p    <= i_src.r0[0];
            r_c0p    <= i_src.c0[0];
            r_rcl    <= rcl;
            r_ccl    <= ccl;
        end
    end

    assign r1p = r_rcl ? r_r0p : !r_r0p;
    assign c1p = r_ccl ? r_c0p : !r_c0p;

    always_comb begin
        o_quad.hit = r_inside;
        o_quad.fr  = r_fr;
        o_quad.fc  = r_fc;
        o_quad.a   = rd[{r_r0p, r_c0p}];
        o_quad.b   = rd[{r_r0p, c1p}];
        o_quad.c   = rd[{r1p, r_c0p}];
        o_quad.d   = rd[{r1p, c1p}];
    end

    assign o_valid = r_v4;

endmodule

### hdl/irb_blend.sv
module irb_blend import irb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_quad     i_quad,
    output logic      o_ready,
    irb_res_if.source o_res
);

    logic rdy5, rdy6, rdy7;

    logic                 r_v5, r_v6, r_v7;
    logic                 r_in5, r_in6, r_in7;
    logic [FRAC_BITS-1:0] r_fr5;
    logic [TOP_W-1:0]     r_top5, r_bot5;
    logic [ACC_W-1:0]     r_pt6, r_pb6;
    logic [PIX_W-1:0]     r_pix7;

    logic [WGT_W-1:0]   n_wc, n_wr;
    logic [TOP_W-1:0]   n_top, n_bot;
    logic [ACC_W-1:0]   n_pt, n_pb, n_sum;
    logic [PIX_W:0]     n_val;
    logic [PIX_W-1:0]   n_pix;

    assign rdy7    = !r_v7 || o_res.ready;
    assign rdy6    = !r_v6 || rdy7;
    assign rdy5    = !r_v5 || rdy6;
    assign o_ready = rdy5;

    // stage 5: blend along the row
    always_comb begin
        n_wc  = WGT_W'(ONE) - WGT_W'(i_quad.fc);
        n_top = TOP_W'((TOP_W+1)'(n_wc) * (TOP_W+1)'(i_quad.a)
                     + (TOP_W+1)'(i_quad.fc) * (TOP_W+1)'(i_quad.b));
        n_bot = TOP_W'((TOP_W+1)'(n_wc) * (TOP_W+1)'(i_quad.c)
                     + (TOP_W+1)'(i_quad.fc) * (TOP_W+1)'(i_quad.d));
    end

    // stage 6: column weights
    always_comb begin
        n_wr = WGT_W'(ONE) - WGT_W'(r_fr5);
        n_pt = ACC_W'(n_wr) * ACC_W'(r_top5);
        n_pb = ACC_W'(r_fr5) * ACC_W'(r_bot5);
    end

    // stage 7: round half up and saturate
    always_comb begin
        n_sum = r_pt6 + r_pb6 + ACC_W'(RND);
        n_val = n_sum[ACC_W-1:2*FRAC_BITS];
        if (n_val > (PIX_W+1)'(255)) begin
            n_pix = '1;
        end else begin
            n_pix = n_val[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (rdy5) begin
                r_v5 <= i_valid;
            end
            if (rdy6) begin
                r_v6 <= r_v5;
            end
            if (rdy7) begin
                r_v7 <= r_v6;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5 && i_valid) begin
            r_in5  <= i_quad.hit;
            r_fr5  <= i_quad.fr;
            r_top5 <= n_top;
            r_bot5 <= n_bot;
        end
        if (rdy6 && r_v5) begin
            r_in6 <= r_in5;
            r_pt6 <= n_pt;
            r_pb6 <= n_pb;
        end
        if (rdy7 && r_v6) begin
            r_in7  <= r_in6;
            r_pix7 <= r_in6 ? n_pix : '0;
        end
    end

    assign o_res.valid      = r_v7;
    assign o_res.pixel_out  = r_pix7;
    assign o_res.inside_res = r_in7;

endmodule
